[rtl/ral_pkg.sv]
// ---------------------------------------------------------------------------
// ral_pkg
// Shared types and constants for the contiguous array list block.
// ---------------------------------------------------------------------------
package ral_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND     = 3'd0,
        MODE_INSERT     = 3'd1,
        MODE_REMOVE_AT  = 3'd2,
        MODE_REMOVE_VAL = 3'd3,
        MODE_REPLACE    = 3'd4,
        MODE_FIND       = 3'd5,
        MODE_READ       = 3'd6
    } ral_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } ral_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_READ,
        S_DONE
    } ral_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } ral_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value_out;
        logic [POS_W-1:0]         position_out;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } ral_result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ral_mem_req_t;

endpackage

[rtl/ral_req_if.sv]
// ---------------------------------------------------------------------------
// ral_req_if
// Request channel: valid/ready handshake carrying one list operation.
// ---------------------------------------------------------------------------
interface ral_req_if
    import ral_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);

endinterface

[rtl/ral_rsp_if.sv]
// ---------------------------------------------------------------------------
// ral_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ---------------------------------------------------------------------------
interface ral_rsp_if
    import ral_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value_out;
    logic [POS_W-1:0]         position_out;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;

    modport source (output valid, status, value_out, position_out, count, is_empty,
                    input ready);
    modport sink   (input valid, status, value_out, position_out, count, is_empty,
                    output ready);

endinterface

[rtl/ral_ram.sv]
// ---------------------------------------------------------------------------
// ral_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ral_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ral_ctrl.sv]
// ---------------------------------------------------------------------------
// ral_ctrl
// Sequencer: decodes a transaction, walks the entry RAM one address per
// cycle (scan, shift up, shift down); scan and shift down share the last-entry compare.
// ---------------------------------------------------------------------------
module ral_ctrl
    import ral_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  ral_item_t    req,
    output logic         res_valid,
    input  logic         res_ready,
    output ral_result_t  res,
    output ral_mem_req_t mem,
    input  logic [DATA_W-1:0] rdata
);

    ral_state_t        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0] rd_reg, rd_next;
    logic              first_reg, first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] vout_reg, vout_next;
    logic [ADDR_W-1:0] pout_reg, pout_next;

    logic              full;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [ADDR_W-1:0] pos_addr;
    logic              rd_last;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_addr = ADDR_W'(req.position);
    assign rd_last  = (CNT_W'(rd_reg) == (count_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rd_reg     <= rd_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        pout_reg   <= pout_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rd_next     = rd_reg;
        first_next  = first_reg;
        count_next  = count_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        pout_next   = pout_reg;
        mem.we      = 1'b0;
        mem.waddr   = rd_reg;
        mem.wdata   = val_reg;
        mem.raddr   = rd_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    mode_next   = req.mode;
                    pos_next    = pos_addr;
                    val_next    = req.value;
                    status_next = ST_OK;
                    vout_next   = '0;
                    pout_next   = '0;
                    first_next  = 1'b0;
                    state_next  = S_DONE;
                    case (req.mode)
                        MODE_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem.we     = 1'b1;
                                mem.waddr  = ADDR_W'(count_reg);
                                mem.wdata  = req.value;
                                pout_next  = ADDR_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_ext > cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                mem.we     = 1'b1;
                                mem.waddr  = pos_addr;
                                mem.wdata  = req.value;
                                pout_next  = pos_addr;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                mem.raddr  = ADDR_W'(count_reg - CNT_W'(1));
                                rd_next    = ADDR_W'(count_reg - CNT_W'(1));
                                state_next = S_SHIFT_UP;
                            end
                        end
                        MODE_REMOVE_AT:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem.raddr  = pos_addr;
                                rd_next    = pos_addr;
                                first_next = 1'b1;
                                pout_next  = pos_addr;
                                state_next = S_SHIFT_DN;
                            end
                        end
                        MODE_REMOVE_VAL, MODE_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                mem.raddr  = '0;
                                rd_next    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_REPLACE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = pos_addr;
                                mem.wdata = req.value;
                                pout_next = pos_addr;
                            end
                        end
                        MODE_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem.raddr  = pos_addr;
                                pout_next  = pos_addr;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rdata == val_reg)
                begin
                    pout_next = rd_reg;
                    if (mode_reg == MODE_FIND)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem.raddr  = rd_reg;
                        first_next = 1'b1;
                        state_next = S_SHIFT_DN;
                    end
                end
                else if (rd_last)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem.raddr = rd_reg + ADDR_W'(1);
                    rd_next   = rd_reg + ADDR_W'(1);
                end
            end

            S_SHIFT_DN:
            begin
                if (first_reg)
                begin
                    vout_next  = rdata;
                    first_next = 1'b0;
                end
                else
                begin
                    mem.we    = 1'b1;
                    mem.waddr = rd_reg - ADDR_W'(1);
                    mem.wdata = rdata;
                end
                if (rd_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem.raddr = rd_reg + ADDR_W'(1);
                    rd_next   = rd_reg + ADDR_W'(1);
                end
            end

            S_SHIFT_UP:
            begin
                mem.we    = 1'b1;
                mem.waddr = rd_reg + ADDR_W'(1);
                mem.wdata = rdata;
                if (rd_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem.raddr = rd_reg - ADDR_W'(1);
                    rd_next   = rd_reg - ADDR_W'(1);
                end
            end

            S_PUT:
            begin
                mem.we     = 1'b1;
                mem.waddr  = pos_reg;
                mem.wdata  = val_reg;
                pout_next  = pos_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_READ:
            begin
                vout_next  = rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status       = status_reg;
    assign res.value_out    = vout_reg;
    assign res.position_out = POS_W'(pout_reg);
    assign res.count        = COUNT_W'(count_reg);
    assign res.is_empty     = (count_reg == '0);

endmodule

[rtl/contiguous_array_list_top.sv]
// ---------------------------------------------------------------------------
// contiguous_array_list_top
// Fixed-capacity ordered list of signed words with shift insert and delete.
// ---------------------------------------------------------------------------
// One transaction at a time; req.ready is high only while the sequencer is
// idle. Entries live in a one-write, one-read RAM with registered read, and
// every shift or search moves one entry per cycle through that port pair.
// From accept to a result in the output register (n = count before the op,
// p = position): append, replace, mode 7 and decode errors go straight to
// done; read passes the read state; insert shifts entries n-1 down to p up
// by one, then writes p (direct if p equals n); remove at shifts later
// entries down; find scans to a match; remove value scans, then shifts down.
// The output register lets the next request be accepted while a result waits.
// The entry RAM has no reset; only entries below the count are ever read.
// ---------------------------------------------------------------------------
module contiguous_array_list_top
    import ral_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ral_req_if.sink   req,
    ral_rsp_if.source rsp
);

    ral_item_t    item;
    ral_result_t  res;
    ral_mem_req_t mem;
    logic [DATA_W-1:0] rdata;
    logic         res_valid;
    logic         res_ready;

    logic         out_valid_reg, out_valid_next;
    ral_result_t  out_reg, out_next;

    assign item.mode     = req.mode;
    assign item.position = req.position;
    assign item.value    = req.value;

    ral_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem       (mem),
        .rdata     (rdata)
    );

    ral_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.value_out    = out_reg.value_out;
    assign rsp.position_out = out_reg.position_out;
    assign rsp.count        = out_reg.count;
    assign rsp.is_empty     = out_reg.is_empty;

endmodule

[rtl/ral_checker.sv]
// ---------------------------------------------------------------------------
// ral_checker
// Port-level assertions for the contiguous array list, bound to the top.
// ---------------------------------------------------------------------------
module ral_checker
    import ral_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STATUS_W-1:0]      status,
    input logic signed [DATA_W-1:0] value_out,
    input logic [POS_W-1:0]         position_out,
    input logic [COUNT_W-1:0]       count,
    input logic                     is_empty
);

    // stalled transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(value_out)
            && $stable(position_out) && $stable(count) && $stable(is_empty))
        else $error("response changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (value_out == '0) && (position_out == '0))
        else $error("error result carries nonzero payload");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
        else $error("full status with list not at capacity");

endmodule

bind contiguous_array_list_top ral_checker u_ral_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .value_out    (rsp.value_out),
    .position_out (rsp.position_out),
    .count        (rsp.count),
    .is_empty     (rsp.is_empty)
);
